@@ hw/rtl/ffpra_pkg.sv @@
// ----------------------------------------------------------------------------
// ffpra_pkg
// Shared widths, status and operation codes and parameter defaults of the page
// range allocator.
// ----------------------------------------------------------------------------
package ffpra_pkg;

    localparam int PAGE_W  = 16;   // page number
    localparam int LEN_W   = 17;   // page count, hole length
    localparam int BUMP_W  = 17;   // bump pointer
    localparam int SUM_W   = 18;   // bump pointer plus a page count
    localparam int WIN_W   = 21;   // window size, up to one mebipage
    localparam int ENTRY_W = PAGE_W + LEN_W;

    localparam int DEF_HOLE_SLOTS   = 2048;
    localparam int DEF_WINDOW_PAGES = 65536;
    localparam int DEF_START_PAGE   = 256;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_LEAKED    = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

endpackage

@@ hw/rtl/ffpra_ram.sv @@
// ----------------------------------------------------------------------------
// ffpra_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffpra_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2048
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/first_fit_page_range_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_page_range_allocator
// First-fit page range allocator over a hole list held in one RAM, with a
// bump pointer behind it for requests that no hole can serve.
//
// Channel    Direction  Handshake              Beat
// request    in         start && !busy         operation, page_count,
//                                              free_base_page
// result     out        done (one-cycle pulse) result_page, status
//
// A free, or an allocate with an empty hole list, returns its beat in the cycle
// after acceptance and leaves busy low.
// An allocate with holes reads the holes in order through the RAM read port
// in S_SCAN, then on an exact fit fetches the last hole in S_MOVE; done is
// registered from the final step. Scan length is bounded by hole_count.
// Reset clears hole_count and loads the bump pointer with START_PAGE; the
// RAM is not cleared, as only entries below hole_count are ever used.
// The receiver cannot stall: done is a strobe; the beat holds until the next one.
// ----------------------------------------------------------------------------
module first_fit_page_range_allocator #(
    parameter int HOLE_SLOTS   = ffpra_pkg::DEF_HOLE_SLOTS,
    parameter int WINDOW_PAGES = ffpra_pkg::DEF_WINDOW_PAGES,
    parameter int START_PAGE   = ffpra_pkg::DEF_START_PAGE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [ffpra_pkg::LEN_W-1:0]   page_count,
    input  logic [ffpra_pkg::PAGE_W-1:0]  free_base_page,
    output logic                          done,
    output logic [ffpra_pkg::PAGE_W-1:0]  result_page,
    output ffpra_pkg::status_t            status
);

    import ffpra_pkg::*;

    localparam int AW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
    localparam int CW = $clog2(HOLE_SLOTS + 1);

    localparam logic [CW-1:0]     SLOTS_C  = CW'(HOLE_SLOTS);
    localparam logic [WIN_W-1:0]  WINDOW_C = WIN_W'(WINDOW_PAGES);
    localparam logic [BUMP_W-1:0] START_C  = BUMP_W'(START_PAGE);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_MOVE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       hole_count_reg, hole_count_next;
    logic [BUMP_W-1:0]   bump_reg, bump_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic                done_reg, done_next;
    logic [PAGE_W-1:0]   result_page_reg, result_page_next;
    status_t             status_reg, status_next;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_wr_data;
    logic [AW-1:0]       ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    logic [PAGE_W-1:0]   rd_base;
    logic [LEN_W-1:0]    rd_len;
    logic [CW:0]         idx_inc;
    logic [CW-1:0]       last_hole;
    logic [LEN_W-1:0]    bump_count;
    logic [SUM_W-1:0]    bump_sum;
    logic                exhausted;

    ffpra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HOLE_SLOTS)
    ) u_holes (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_base   = ram_rd_data[ENTRY_W-1:LEN_W];
    assign rd_len    = ram_rd_data[LEN_W-1:0];
    assign idx_inc   = (CW + 1)'(idx_reg) + (CW + 1)'(1);
    assign last_hole = hole_count_reg - CW'(1);

    // One bump check, fed by the live request in idle or the held count
    assign bump_count = (state_reg == S_IDLE) ? page_count : count_reg;
    assign bump_sum   = {1'b0, bump_reg} + {1'b0, bump_count};
    assign exhausted  = bump_reg[BUMP_W-1] || (WIN_W'(bump_sum) > WINDOW_C);

    always_comb
    begin
        state_next       = state_reg;
        hole_count_next  = hole_count_reg;
        bump_next        = bump_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        page_next        = page_reg;
        done_next        = 1'b0;
        result_page_next = result_page_reg;
        status_next      = status_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = idx_reg;
        ram_wr_data      = ram_rd_data;
        ram_rd_addr      = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                ram_rd_addr = '0;
                if (start)
                begin
                    if (operation == OP_FREE)
                    begin
                        done_next        = 1'b1;
                        result_page_next = '0;
                        if (hole_count_reg < SLOTS_C)
                        begin
                            // append the range as a new hole
                            ram_wr_en       = 1'b1;
                            ram_wr_addr     = hole_count_reg[AW-1:0];
                            ram_wr_data     = {free_base_page, page_count};
                            hole_count_next = hole_count_reg + CW'(1);
                            status_next     = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_LEAKED;
                        end
                    end
                    else if (hole_count_reg == '0)
                    begin
                        done_next = 1'b1;
                        if (exhausted)
                        begin
                            result_page_next = '0;
                            status_next      = ST_EXHAUSTED;
                        end
                        else
                        begin
                            result_page_next = bump_reg[PAGE_W-1:0];
                            status_next      = ST_OK;
                            bump_next        = bump_sum[BUMP_W-1:0];
                        end
                    end
                    else
                    begin
                        idx_next   = '0;
                        count_next = page_count;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (rd_len >= count_reg)
                begin
                    if (rd_len == count_reg)
                    begin
                        // exact fit: fetch the last hole to fill this slot
                        ram_rd_addr = last_hole[AW-1:0];
                        page_next   = rd_base;
                        state_next  = S_MOVE;
                    end
                    else
                    begin
                        // shrink the hole from its low end
                        ram_wr_en        = 1'b1;
                        ram_wr_addr      = idx_reg;
                        ram_wr_data      = {rd_base + count_reg[PAGE_W-1:0],
                                            rd_len - count_reg};
                        done_next        = 1'b1;
                        result_page_next = rd_base;
                        status_next      = ST_OK;
                        state_next       = S_IDLE;
                    end
                end
                else if (idx_inc < {1'b0, hole_count_reg})
                begin
                    idx_next    = idx_inc[AW-1:0];
                    ram_rd_addr = idx_inc[AW-1:0];
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (exhausted)
                    begin
                        result_page_next = '0;
                        status_next      = ST_EXHAUSTED;
                    end
                    else
                    begin
                        result_page_next = bump_reg[PAGE_W-1:0];
                        status_next      = ST_OK;
                        bump_next        = bump_sum[BUMP_W-1:0];
                    end
                end
            end

            S_MOVE:
            begin
                ram_wr_en        = 1'b1;
                ram_wr_addr      = idx_reg;
                ram_wr_data      = ram_rd_data;
                hole_count_next  = last_hole;
                done_next        = 1'b1;
                result_page_next = page_reg;
                status_next      = ST_OK;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hole_count_reg <= '0;
            bump_reg       <= START_C;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hole_count_reg <= hole_count_next;
            bump_reg       <= bump_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        count_reg       <= count_next;
        page_reg        <= page_next;
        result_page_reg <= result_page_next;
        status_reg      <= status_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign result_page = result_page_reg;
    assign status      = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hole_count_reg <= SLOTS_C)
        else $error("hole count above table size");

    a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_inc <= {1'b0, hole_count_reg}))
        else $error("scan index past last hole");

    a_move_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |=> (done_reg && state_reg == S_IDLE))
        else $error("exact fit did not finish after slot move");

    a_leak_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_LEAKED) |-> (hole_count_reg == SLOTS_C))
        else $error("leak reported with room in hole table");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done_reg || state_reg == S_SCAN))
        else $error("accepted beat neither answered nor scanning");

endmodule
